FILE: sv/b64d_pkg.sv
// shared types, constants and the alphabet lookup for the base64 stream decoder
package b64d_pkg;

   localparam int unsigned QUEUE_DEPTH = 2;
   localparam logic [7:0] PAD_CHAR = 8'h3D;

   localparam logic [1:0] POS_FIRST  = 2'd0;
   localparam logic [1:0] POS_SECOND = 2'd1;
   localparam logic [1:0] POS_THIRD  = 2'd2;
   localparam logic [1:0] POS_FOURTH = 2'd3;

   typedef struct packed {
      logic [5:0] sextet;
      logic       is_pad;
      logic       invalid;
      logic       last;
   } sym_class_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_valid;
      logic       end_of_text;
      logic       decode_error;
   } result_type;

   // maps one character to its class; sextet is zero when not in the alphabet
   function automatic sym_class_type classify(input logic [7:0] c, input logic last);
      sym_class_type r;
      r.sextet  = 6'd0;
      r.is_pad  = (c == PAD_CHAR);
      r.invalid = 1'b0;
      r.last    = last;
      if (c >= 8'h41 && c <= 8'h5A) begin
         r.sextet = 6'(c - 8'h41);
      end else if (c >= 8'h61 && c <= 8'h7A) begin
         r.sextet = 6'(c - 8'h61 + 8'd26);
      end else if (c >= 8'h30 && c <= 8'h39) begin
         r.sextet = 6'(c - 8'h30 + 8'd52);
      end else if (c == 8'h2B) begin
         r.sextet = 6'd62;
      end else if (c == 8'h2F) begin
         r.sextet = 6'd63;
      end else if (c != PAD_CHAR) begin
         r.invalid = 1'b1;
      end
      return r;
   endfunction

endpackage

FILE: sv/b64d_fifo.sv
// small register queue used between the decoder stages and on the result side
module b64d_fifo #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wptr_ff, wptr_in;
   logic [PW-1:0]    rptr_ff, rptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rptr_ff];

   always_comb begin
      wptr_in  = wptr_ff;
      rptr_in  = rptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wptr_in = (wptr_ff == PW'(DEPTH - 1)) ? '0 : wptr_ff + 1'b1;
      end
      if (do_pop) begin
         rptr_in = (rptr_ff == PW'(DEPTH - 1)) ? '0 : rptr_ff + 1'b1;
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wptr_ff] <= push_data;
      end
   end

endmodule

FILE: sv/b64d_front.sv
// front stage: takes characters and classifies them through the alphabet
module b64d_front (
   input  logic                    req_push,
   input  logic [7:0]              req_symbol,
   input  logic                    req_last_symbol,
   input  logic                    queue_full,
   output logic                    req_full,
   output logic                    queue_push,
   output b64d_pkg::sym_class_type queue_item
);
   import b64d_pkg::*;

   assign req_full   = queue_full;
   assign queue_push = req_push && !queue_full;
   assign queue_item = classify(req_symbol, req_last_symbol);

endmodule

FILE: sv/b64d_back.sv
// back stage: group tracking, padding rules, byte packing and the sticky error
module b64d_back (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    item_avail,
   input  b64d_pkg::sym_class_type item,
   output logic                    item_pop,
   input  logic                    out_full,
   output logic                    out_push,
   output b64d_pkg::result_type    out_result
);
   import b64d_pkg::*;

   logic [1:0] pos_ff, pos_in;
   logic [5:0] held_ff, held_in;
   logic       pad_pending_ff, pad_pending_in;
   logic       error_ff, error_in;
   logic       take;
   logic       err;
   logic       have_byte;
   logic [7:0] byte_val;
   logic [1:0] pos_next;

   assign take     = item_avail && !out_full;
   assign item_pop = take;
   assign pos_next = pos_ff + 2'd1;

   always_comb begin
      err            = error_ff;
      have_byte      = 1'b0;
      byte_val       = 8'd0;
      held_in        = held_ff;
      pad_pending_in = pad_pending_ff;
      if (pad_pending_ff) begin
         // only the closing pad of the text may follow a pad at position three
         if (!item.is_pad || !item.last) err = 1'b1;
         pad_pending_in = 1'b0;
      end else if (item.is_pad) begin
         case (pos_ff)
            POS_THIRD: begin
               pad_pending_in = 1'b1;
               if (item.last) err = 1'b1;
            end
            POS_FOURTH: begin
               if (!item.last) err = 1'b1;
            end
            default: err = 1'b1;
         endcase
      end else if (item.invalid) begin
         err = 1'b1;
      end else begin
         case (pos_ff)
            POS_FIRST: begin
               held_in = item.sextet;
            end
            POS_SECOND: begin
               byte_val  = {held_ff, item.sextet[5:4]};
               held_in   = {2'b00, item.sextet[3:0]};
               have_byte = 1'b1;
            end
            POS_THIRD: begin
               byte_val  = {held_ff[3:0], item.sextet[5:2]};
               held_in   = {4'b0000, item.sextet[1:0]};
               have_byte = 1'b1;
            end
            default: begin
               byte_val  = {held_ff[1:0], item.sextet};
               held_in   = 6'd0;
               have_byte = 1'b1;
            end
         endcase
      end
      // incomplete final group
      if (item.last && pos_next != POS_FIRST) err = 1'b1;
      if (err) begin
         have_byte = 1'b0;
         byte_val  = 8'd0;
      end
   end

   always_comb begin
      pos_in   = pos_ff;
      error_in = error_ff;
      if (take) begin
         if (item.last) begin
            pos_in   = POS_FIRST;
            error_in = 1'b0;
         end else begin
            pos_in   = pos_next;
            error_in = err;
         end
      end
   end

   assign out_push                = take && (have_byte || item.last);
   assign out_result.data_byte    = byte_val;
   assign out_result.byte_valid   = have_byte;
   assign out_result.end_of_text  = item.last;
   assign out_result.decode_error = item.last && err;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff         <= POS_FIRST;
         held_ff        <= 6'd0;
         pad_pending_ff <= 1'b0;
         error_ff       <= 1'b0;
      end else begin
         pos_ff   <= pos_in;
         error_ff <= error_in;
         if (take) begin
            held_ff        <= item.last ? 6'd0 : held_in;
            pad_pending_ff <= item.last ? 1'b0 : pad_pending_in;
         end
      end
   end

endmodule

FILE: sv/base64_stream_decoder_top.sv
// top level of the base64 stream decoder
// Decodes standard base64 text one character per clock while the result queue has room. A
// character is classified through the alphabet on the way into a short queue, and the decode
// stage then packs six-bit symbols into bytes at that rate and writes each completed byte, and
// the end of text record with its error flag, into the result queue. A character is registered
// in the short queue and its result in the result queue before reaching the result ports;
// characters that neither complete a byte nor end the text give no result. Both queues are
// QUEUE_DEPTH entries deep, so the input keeps taking characters while a result waits to be
// popped, until the queues fill. On a result with end_of_text and decode_error high the whole
// text is invalid and the bytes already delivered for it are to be discarded.
module base64_stream_decoder_top #(
   parameter int unsigned QUEUE_DEPTH = b64d_pkg::QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic [7:0] req_symbol,
   input  logic       req_last_symbol,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic [7:0] rsp_data_byte,
   output logic       rsp_byte_valid,
   output logic       rsp_end_of_text,
   output logic       rsp_decode_error
);
   import b64d_pkg::*;

   sym_class_type front_item;
   sym_class_type mid_head;
   result_type    back_result;
   result_type    rsp_head;
   logic          mid_push, mid_full, mid_pop, mid_empty;
   logic          out_push, out_full;

   b64d_front u_front (
      .req_push        (req_push),
      .req_symbol      (req_symbol),
      .req_last_symbol (req_last_symbol),
      .queue_full      (mid_full),
      .req_full        (req_full),
      .queue_push      (mid_push),
      .queue_item      (front_item)
   );

   b64d_fifo #(
      .WIDTH ($bits(sym_class_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_mid_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (mid_push),
      .push_data (front_item),
      .full      (mid_full),
      .pop       (mid_pop),
      .pop_data  (mid_head),
      .empty     (mid_empty)
   );

   b64d_back u_back (
      .clock      (clock),
      .reset      (reset),
      .item_avail (!mid_empty),
      .item       (mid_head),
      .item_pop   (mid_pop),
      .out_full   (out_full),
      .out_push   (out_push),
      .out_result (back_result)
   );

   b64d_fifo #(
      .WIDTH ($bits(result_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (out_push),
      .push_data (back_result),
      .full      (out_full),
      .pop       (rsp_pop),
      .pop_data  (rsp_head),
      .empty     (rsp_empty)
   );

   assign rsp_data_byte    = rsp_head.data_byte;
   assign rsp_byte_valid   = rsp_head.byte_valid;
   assign rsp_end_of_text  = rsp_head.end_of_text;
   assign rsp_decode_error = rsp_head.decode_error;

   // an error is only ever reported on the end of text record
   a_error_at_end : assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_decode_error) |-> rsp_end_of_text)
      else $error("decode error without end of text");

   // a rejected text carries no byte on its final record
   a_no_byte_on_error : assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_decode_error) |-> !rsp_byte_valid)
      else $error("byte delivered with decode error");

   // records without a byte only exist to mark the end of text
   a_empty_record_is_end : assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_byte_valid) |-> (rsp_end_of_text && rsp_data_byte == 8'd0))
      else $error("result without byte or end of text");

   // every character leaving the mid queue lands in the decode stage that cycle
   a_mid_pop_needs_room : assert property (@(posedge clock) disable iff (reset)
      mid_pop |-> (!mid_empty && !out_full))
      else $error("mid queue popped without room for the result");

endmodule

FILE: sim/base64_stream_decoder_top_tb.sv
// self-checking testbench for the base64 stream decoder top level
module base64_stream_decoder_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import b64d_pkg::*;

   localparam int RANDOM_CHARS = 650;
   localparam int QUIET_LIMIT  = 1000;
   localparam int DRAIN_CYCLES = 8;

   typedef struct packed {
      logic [7:0] ch;
      logic       fin;
   } text_char_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_push = 1'b0;
   logic       req_full;
   logic [7:0] req_symbol = 8'h00;
   logic       req_last_symbol = 1'b0;
   logic       rsp_empty;
   logic       rsp_pop = 1'b0;
   logic [7:0] rsp_data_byte;
   logic       rsp_byte_valid;
   logic       rsp_end_of_text;
   logic       rsp_decode_error;

   text_char_type text_chars[$];
   result_type predicted_output[$];

   // decoder state as seen by the predictor
   logic [1:0] grp_pos = POS_FIRST;
   logic [5:0] carry_bits = '0;
   logic       pad_wait = 1'b0;
   logic       text_bad = 1'b0;

   int chars_queued = 0;
   int chars_sent = 0;
   int texts_sent = 0;
   int results_seen = 0;
   int bad_texts = 0;
   int mismatch_count = 0;
   int quiet_cycles = 0;
   logic calm;

   // no idling on either side for a stretch in the middle of the random part
   assign calm = (chars_sent >= 300) && (chars_sent < 450);

   base64_stream_decoder_top dut (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_symbol       (req_symbol),
      .req_last_symbol  (req_last_symbol),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_data_byte    (rsp_data_byte),
      .rsp_byte_valid   (rsp_byte_valid),
      .rsp_end_of_text  (rsp_end_of_text),
      .rsp_decode_error (rsp_decode_error)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // bit 6 flags a member of the alphabet
   function automatic logic [6:0] sextet_value(input logic [7:0] ch);
      if (ch >= "A" && ch <= "Z") return {1'b1, 6'(ch - "A")};
      if (ch >= "a" && ch <= "z") return {1'b1, 6'(ch - "a" + 26)};
      if (ch >= "0" && ch <= "9") return {1'b1, 6'(ch - "0" + 52)};
      if (ch == "+") return {1'b1, 6'd62};
      if (ch == "/") return {1'b1, 6'd63};
      return 7'd0;
   endfunction

   function automatic logic [7:0] alpha_char(input int idx);
      if (idx < 26) return 8'("A" + idx);
      if (idx < 52) return 8'("a" + idx - 26);
      if (idx < 62) return 8'("0" + idx - 52);
      if (idx == 62) return "+";
      return "/";
   endfunction

   // advances the predicted state by one character; returns 1 when a result is due
   function automatic bit decode_char(input logic [7:0] ch, input logic fin,
                                      output result_type res);
      logic [6:0] sv;
      logic [1:0] pos;
      logic       bad;
      logic       got;
      logic [7:0] b;
      sv = sextet_value(ch);
      pos = grp_pos;
      bad = text_bad;
      got = 1'b0;
      b = 8'h00;
      if (pad_wait) begin
         if (ch != PAD_CHAR || !fin) bad = 1'b1;
         pad_wait = 1'b0;
      end else if (ch == PAD_CHAR) begin
         case (pos)
            POS_THIRD: begin
               pad_wait = 1'b1;
               if (fin) bad = 1'b1;
            end
            POS_FOURTH: begin
               if (!fin) bad = 1'b1;
            end
            default: bad = 1'b1;
         endcase
      end else if (!sv[6]) begin
         bad = 1'b1;
      end else begin
         case (pos)
            POS_FIRST: carry_bits = sv[5:0];
            POS_SECOND: begin
               b = {carry_bits, sv[5:4]};
               carry_bits = {2'b00, sv[3:0]};
               got = 1'b1;
            end
            POS_THIRD: begin
               b = {carry_bits[3:0], sv[5:2]};
               carry_bits = {4'b0000, sv[1:0]};
               got = 1'b1;
            end
            default: begin
               b = {carry_bits[1:0], sv[5:0]};
               carry_bits = '0;
               got = 1'b1;
            end
         endcase
      end
      pos = pos + 2'd1;
      if (fin && pos != POS_FIRST) bad = 1'b1;
      if (bad) begin
         got = 1'b0;
         b = 8'h00;
      end
      res.data_byte = b;
      res.byte_valid = got;
      res.end_of_text = fin;
      res.decode_error = bad;
      if (fin) begin
         grp_pos = POS_FIRST;
         carry_bits = '0;
         pad_wait = 1'b0;
         text_bad = 1'b0;
         return 1'b1;
      end
      grp_pos = pos;
      text_bad = bad;
      return got;
   endfunction

   task automatic add_char(input logic [7:0] ch, input logic fin);
      text_chars.push_back('{ch: ch, fin: fin});
      chars_queued++;
   endtask

   task automatic add_string(input string s);
      for (int i = 0; i < s.len(); i++) add_char(s[i], i == s.len() - 1);
   endtask

   // mostly well-formed texts, some corrupted, truncated or pure noise
   task automatic add_random_text();
      logic [7:0] txt[$];
      int kind;
      int groups;
      int pads;
      bit fin_flag;
      kind = $urandom_range(99);
      groups = ($urandom_range(9) == 0) ? $urandom_range(4, 8) : $urandom_range(1, 3);
      fin_flag = 1'b1;
      for (int i = 0; i < groups * 4; i++) txt.push_back(alpha_char($urandom_range(63)));
      pads = $urandom_range(2);
      if (pads >= 1) txt[txt.size() - 1] = PAD_CHAR;
      if (pads == 2) txt[txt.size() - 2] = PAD_CHAR;
      if (kind >= 65 && kind < 75) begin
         txt[$urandom_range(txt.size() - 1)] = $urandom_range(1) ? PAD_CHAR : 8'($urandom);
      end else if (kind >= 75 && kind < 85) begin
         repeat ($urandom_range(1, 3)) void'(txt.pop_back());
      end else if (kind >= 85 && kind < 90) begin
         txt.insert($urandom_range(txt.size() - 1), PAD_CHAR);
      end else if (kind >= 90) begin
         // raw bytes; an open text carries its state into the next one
         txt.delete();
         repeat ($urandom_range(1, 8)) txt.push_back(8'($urandom));
         fin_flag = 1'($urandom_range(1));
      end
      for (int i = 0; i < txt.size(); i++) add_char(txt[i], fin_flag && i == txt.size() - 1);
   endtask

   task automatic wait_drained();
      while (text_chars.size() != 0 || predicted_output.size() != 0) @(posedge clock);
   endtask

   task automatic check_field(input string name, input logic [7:0] want,
                              input logic [7:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   // input side: offer the front character at the falling edge
   always @(negedge clock) begin
      if (!reset && text_chars.size() != 0 && (calm || $urandom_range(99) >= 30)) begin
         req_push <= 1'b1;
         req_symbol <= text_chars[0].ch;
         req_last_symbol <= text_chars[0].fin;
      end else begin
         req_push <= 1'b0;
         req_symbol <= 8'($urandom);
         req_last_symbol <= 1'($urandom);
      end
   end

   always @(posedge clock) begin : take_char
      result_type res;
      if (!reset && req_push && !req_full) begin
         void'(text_chars.pop_front());
         if (decode_char(req_symbol, req_last_symbol, res)) predicted_output.push_back(res);
         chars_sent <= chars_sent + 1;
         if (req_last_symbol) texts_sent <= texts_sent + 1;
      end
   end

   // result side
   always @(negedge clock) begin
      rsp_pop <= !reset && (calm || $urandom_range(99) >= 30);
   end

   always @(posedge clock) begin : take_result
      result_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         results_seen <= results_seen + 1;
         if (predicted_output.size() == 0) begin
            $display("%0t: result with none expected, actual byte %0h valid %0b end %0b err %0b",
                     $time, rsp_data_byte, rsp_byte_valid, rsp_end_of_text, rsp_decode_error);
            mismatch_count++;
         end else begin
            want = predicted_output.pop_front();
            check_field("data_byte", want.data_byte, rsp_data_byte);
            check_field("byte_valid", 8'(want.byte_valid), 8'(rsp_byte_valid));
            check_field("end_of_text", 8'(want.end_of_text), 8'(rsp_end_of_text));
            check_field("decode_error", 8'(want.decode_error), 8'(rsp_decode_error));
            if (want.decode_error) bad_texts <= bad_texts + 1;
         end
      end
   end

   // watchdog on cycles with no transfer on either side
   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
         $display("base64_stream_decoder_top: mismatch");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      add_string("//8A");
      add_string("TQ==");
      add_string("TWE=");
      add_char("A", 1'b0);
      add_char(8'h00, 1'b0);
      add_char(8'hFF, 1'b0);
      add_char("/", 1'b1);
      add_string("=");
      add_string("AB=C");
      add_string("AB");
      add_string("QQ=");

      // let everything settle before the random part
      wait_drained();

      while (chars_queued < RANDOM_CHARS) add_random_text();
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("sent %0d characters closing %0d texts, checked %0d results",
               chars_sent, texts_sent, results_seen);
      $display("%0d texts flagged invalid, %0d field mismatches", bad_texts, mismatch_count);
      if (mismatch_count == 0) begin
         $display("base64_stream_decoder_top: match");
      end else begin
         $display("base64_stream_decoder_top: mismatch");
      end
      $finish;
   end

endmodule
